### sv/tlb_page_table_translator_macros.svh
// Assertion macros for the TLB page-table translator.
// Expects clk and rst in scope at the point of use.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// Condition holds at every edge outside reset
`define TLBPT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define TLBPT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define TLBPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tlbpt_pkg.sv
// Shared types and constants for the TLB page-table translator.
// No dependencies.
`default_nettype none

package tlbpt_pkg;

  localparam int ADDR_W  = 20;
  localparam int COUNT_W = 32;
  localparam int FREE_W  = 11;
  localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic reduce;
    logic lookup;
    logic resolve;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic need_reduce;
    logic reduce_last;
  } dp_status_t;

  // Shift-subtract steps needed to bring a vw-bit page number below pc.
  // Zero when pc is a power of two (a mask does it) or already larger.
  function automatic int reduce_steps(input int pc, input int vw);
    int n;
    n = 0;
    if ((pc & (pc - 1)) != 0) begin
      for (int k = 0; k < ADDR_W; k++) begin
        if ((longint'(pc) << k) < (longint'(1) << vw)) begin
          n = k + 1;
        end
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### sv/tlb_page_table_translator.sv
// Virtual-to-physical translator: a request is accepted at a clock edge with
// start high and busy low. It passes through accept, TLB compare with page-table
// read and resolve, with shift-subtract steps in between when PAGE_COUNT is not
// a power of two and the page field can exceed it (0 steps at the defaults).
// The result shows for exactly one cycle with done high, and busy is already low
// then, so the next request can enter in that cycle. The receiver cannot stall.
// After reset the page table is cleared one entry per cycle: busy stays high until
// every entry is cleared, and only then is the first request taken.
// Depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_datapath, tlbpt_ram and the macros header.
`default_nettype none
`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator #(
  parameter int TLB_ENTRIES  = 16,
  parameter int PAGE_COUNT   = 1024,
  parameter int OFFSET_WIDTH = 10
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire  [tlbpt_pkg::ADDR_W-1:0]  virtual_address,
  output logic                          done,
  output logic [tlbpt_pkg::ADDR_W-1:0]  phys_addr,
  output logic                          tlb_hit,
  output logic                          page_fault,
  output logic [tlbpt_pkg::COUNT_W-1:0] hit_total,
  output logic [tlbpt_pkg::COUNT_W-1:0] fault_total
);

  tlbpt_pkg::ctl_cmd_t   cmd;
  tlbpt_pkg::dp_status_t status;

  tlbpt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES  (TLB_ENTRIES),
    .PAGE_COUNT   (PAGE_COUNT),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .virtual_address (virtual_address),
    .phys_addr       (phys_addr),
    .tlb_hit         (tlb_hit),
    .page_fault      (page_fault),
    .hit_total       (hit_total),
    .fault_total     (fault_total)
  );

  // A TLB hit never allocates a frame
  `TLBPT_ASSERT_IMPL(a_hit_not_fault, done, !(tlb_hit && page_fault), "hit and fault together")
  // Done does not stay high after a result
  `TLBPT_ASSERT_NEXT(a_done_single, done, !done, "done held for two cycles")
  // Totals count the request being reported
  `TLBPT_ASSERT_IMPL(a_hit_counted, done && tlb_hit, hit_total != '0, "hit not counted")
  `TLBPT_ASSERT_IMPL(a_fault_counted, done && page_fault, fault_total != '0, "fault not counted")

endmodule

`default_nettype wire

### sv/tlbpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/tlbpt_ctrl.sv
// Sequencer for the translator: clearing pass, page reduction, lookup, resolve.
// Depends on tlbpt_pkg.
`default_nettype none

module tlbpt_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  tlbpt_pkg::dp_status_t  status,
  output tlbpt_pkg::ctl_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOOKUP,
    ST_RESOLVE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = status.need_reduce ? ST_REDUCE : ST_LOOKUP;
        end
      end
      ST_REDUCE: begin
        if (status.reduce_last) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP:  state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd.clear   = (state == ST_CLEAR);
    cmd.load    = (state == ST_IDLE) && start;
    cmd.reduce  = (state == ST_REDUCE);
    cmd.lookup  = (state == ST_LOOKUP);
    cmd.resolve = (state == ST_RESOLVE);
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
      done  <= (state == ST_RESOLVE);
    end
  end

endmodule

`default_nettype wire

### sv/tlbpt_datapath.sv
// Datapath: address split, page reduction, TLB, page table, frame allocator, totals.
// Depends on tlbpt_pkg and tlbpt_ram.
`default_nettype none

module tlbpt_datapath #(
  parameter int TLB_ENTRIES  = 16,
  parameter int PAGE_COUNT   = 1024,
  parameter int OFFSET_WIDTH = 10
) (
  input  wire                               clk,
  input  wire                               rst,
  input  tlbpt_pkg::ctl_cmd_t               cmd,
  output tlbpt_pkg::dp_status_t             status,
  input  wire  [tlbpt_pkg::ADDR_W-1:0]      virtual_address,
  output logic [tlbpt_pkg::ADDR_W-1:0]      phys_addr,
  output logic                              tlb_hit,
  output logic                              page_fault,
  output logic [tlbpt_pkg::COUNT_W-1:0]     hit_total,
  output logic [tlbpt_pkg::COUNT_W-1:0]     fault_total
);

  localparam int ADDR_W    = tlbpt_pkg::ADDR_W;
  localparam int COUNT_W   = tlbpt_pkg::COUNT_W;
  localparam int FREE_W    = tlbpt_pkg::FREE_W;
  localparam int VPN_W     = ADDR_W - OFFSET_WIDTH;
  localparam int PW        = $clog2(PAGE_COUNT);
  localparam int TW        = $clog2(TLB_ENTRIES);
  localparam int RED_STEPS = tlbpt_pkg::reduce_steps(PAGE_COUNT, VPN_W);
  localparam int RC_W      = $clog2(RED_STEPS + 2);
  localparam int DIV_SH    = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
  localparam longint DIV_INIT = longint'(PAGE_COUNT) << DIV_SH;

  // Request registers
  logic [OFFSET_WIDTH-1:0] offset;
  logic [VPN_W-1:0]        rem;
  logic [VPN_W-1:0]        divisor;
  logic [RC_W-1:0]         red_cnt;

  // TLB storage
  logic [PW-1:0]          tlb_page  [TLB_ENTRIES];
  logic [PW-1:0]          tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [TW-1:0]          fill_ptr;

  // Lookup result
  logic          hit_lat;
  logic [PW-1:0] hit_frame;

  // Allocator, totals, clearing pass
  logic [FREE_W-1:0]  next_free;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] fault_count;
  logic [PW-1:0]      clr_cnt;

  // Page table port
  logic          pt_we;
  logic [PW-1:0] pt_waddr;
  logic [PW:0]   pt_wdata;
  logic [PW:0]   pt_rdata;
  logic          pt_mapped;
  logic [PW-1:0] pt_frame;

  // Combinational helpers
  logic [PW+VPN_W-1:0]        page_ext;
  logic [PW-1:0]              page;
  logic [TLB_ENTRIES-1:0]     match;
  logic [TLB_ENTRIES-1:0]     first;
  logic [PW-1:0]              sel_frame;
  logic [PW+FREE_W-1:0]       new_ext;
  logic [PW-1:0]              new_frame;
  logic                       fault;
  logic [PW-1:0]              frame;
  logic [ADDR_W+PW+OFFSET_WIDTH-1:0] pa_ext;

  // Page number after reduction, sized to the page-table index
  assign page_ext = {{PW{1'b0}}, rem};
  assign page     = page_ext[PW-1:0];

  // Status back to the sequencer
  assign status.clear_last  = (clr_cnt == PW'(PAGE_COUNT - 1));
  assign status.need_reduce = (RED_STEPS != 0);
  assign status.reduce_last = (red_cnt == RC_W'(1));

  // TLB compare, lowest matching slot wins
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = tlb_valid[i] && (tlb_page[i] == page);
    end
    first     = match & (~match + 1'b1);
    sel_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      sel_frame = sel_frame | (tlb_frame[i] & {PW{first[i]}});
    end
  end

  // Resolve: TLB hit, page-table hit or fresh frame
  assign pt_mapped = pt_rdata[PW];
  assign pt_frame  = pt_rdata[PW-1:0];
  assign new_ext   = {{PW{1'b0}}, next_free};
  assign new_frame = new_ext[PW-1:0];
  assign fault     = !hit_lat && !pt_mapped;
  assign frame     = hit_lat ? hit_frame : (pt_mapped ? pt_frame : new_frame);
  assign pa_ext    = {{ADDR_W{1'b0}}, frame, offset};

  // Page table write: clearing pass or new mapping
  assign pt_we    = cmd.clear || (cmd.resolve && fault);
  assign pt_waddr = cmd.clear ? clr_cnt : page;
  assign pt_wdata = cmd.clear ? '0 : {1'b1, new_frame};

  tlbpt_ram #(
    .WIDTH (PW + 1),
    .DEPTH (PAGE_COUNT)
  ) u_page_table (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (pt_waddr),
    .wr_data (pt_wdata),
    .rd_en   (cmd.lookup),
    .rd_addr (page),
    .rd_data (pt_rdata)
  );

  // Control state: valid bits, pointers, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid   <= '0;
      fill_ptr    <= '0;
      next_free   <= '0;
      hit_count   <= '0;
      fault_count <= '0;
      clr_cnt     <= '0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.resolve) begin
        if (hit_lat) begin
          if (hit_count != {COUNT_W{1'b1}}) begin
            hit_count <= hit_count + 1'b1;
          end
        end else begin
          tlb_valid[fill_ptr] <= 1'b1;
          fill_ptr <= (fill_ptr == TW'(TLB_ENTRIES - 1)) ? '0 : fill_ptr + 1'b1;
        end
        if (fault) begin
          if (fault_count != {COUNT_W{1'b1}}) begin
            fault_count <= fault_count + 1'b1;
          end
          if (next_free != tlbpt_pkg::FREE_MAX) begin
            next_free <= next_free + 1'b1;
          end
        end
      end
    end
  end

  // Payload: request split, reduction, lookup, TLB fill, results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      offset  <= virtual_address[OFFSET_WIDTH-1:0];
      rem     <= virtual_address[ADDR_W-1:OFFSET_WIDTH];
      divisor <= VPN_W'(DIV_INIT);
      red_cnt <= RC_W'(RED_STEPS);
    end
    if (cmd.reduce) begin
      if (rem >= divisor) begin
        rem <= rem - divisor;
      end
      divisor <= divisor >> 1;
      red_cnt <= red_cnt - 1'b1;
    end
    if (cmd.lookup) begin
      hit_lat   <= |match;
      hit_frame <= sel_frame;
    end
    if (cmd.resolve) begin
      if (!hit_lat) begin
        tlb_page[fill_ptr]  <= page;
        tlb_frame[fill_ptr] <= frame;
      end
      phys_addr  <= pa_ext[ADDR_W-1:0];
      tlb_hit    <= hit_lat;
      page_fault <= fault;
    end
  end

  // Totals already include the request just resolved
  assign hit_total   = hit_count;
  assign fault_total = fault_count;

endmodule

`default_nettype wire
